[sv/bir_pkg.sv]
// ----------------------------------------------------------------------------
// Bilinear image resampler package
// Shared codes, field widths and state types of the resampler and its
// coordinate locator.
// ----------------------------------------------------------------------------
package bir_pkg;

  // Field widths of the item and configuration ports.
  localparam int SAMPLE_W  = 16;
  localparam int COORD_W   = 12;
  localparam int PLANE_W   = 2;
  localparam int SRC_CFG_W = 8;
  localparam int TGT_CFG_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;
  localparam int FRAC_W    = 8;

  // Weight of one tap (0..65536) and the blend accumulator.
  localparam int WGT_W = 17;
  localparam int ACC_W = 34;

  // Item codes.
  localparam logic ACTION_WRITE = 1'b0;
  localparam logic ACTION_READ  = 1'b1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 2'd3;

  // Sequencer of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOCATE,
    ST_FETCH,
    ST_DRAIN,
    ST_FINISH
  } top_state_t;

  // Sequencer of the coordinate locator.
  typedef enum logic [2:0] {
    LOC_IDLE,
    LOC_MUL,
    LOC_PREP,
    LOC_DIV,
    LOC_FIN
  } loc_state_t;

endpackage

[sv/bir_locate.sv]
// ----------------------------------------------------------------------------
// Bilinear resampler coordinate locator
// Maps one destination coordinate to its two clamped source taps and the
// 8-bit blend fraction, using a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module bir_locate
  import bir_pkg::*;
#(
  parameter int MAX_SIDE = 128
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [COORD_W-1:0]           coord,
  input  logic [$clog2(MAX_SIDE+1)-1:0] src,
  input  logic [TGT_CFG_W-1:0]         dst,
  output logic                         done,
  output logic [$clog2(MAX_SIDE)-1:0]  idx_lo,
  output logic [$clog2(MAX_SIDE)-1:0]  idx_hi,
  output logic [FRAC_W-1:0]            frac
);

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int IW = $clog2(MAX_SIDE);
  // Biased quotient: floor position plus one pixel, with 8 fraction bits.
  localparam int QW = SW + FRAC_W;
  localparam int PW = COORD_W + 1 + SW;
  localparam int RW = PW + 1 + FRAC_W;
  localparam int CW = $clog2(QW);

  loc_state_t state, state_next;

  logic [COORD_W-1:0]   coord_r;
  logic [SW-1:0]        src_r;
  logic [TGT_CFG_W-1:0] dst_r;
  logic [PW-1:0]        prod;
  logic [RW-1:0]        rem;
  logic [RW-1:0]        dsh;
  logic [QW-1:0]        quo;
  logic [CW-1:0]        cnt;
  logic [PW:0]          num_sum;
  logic [RW:0]          trial;
  logic [SW-1:0]        hi;
  logic                 div_last;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      LOC_IDLE: if (start) state_next = LOC_MUL;
      LOC_MUL:  state_next = LOC_PREP;
      LOC_PREP: state_next = LOC_DIV;
      LOC_DIV:  if (div_last) state_next = LOC_FIN;
      LOC_FIN:  state_next = LOC_IDLE;
      default:  state_next = LOC_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    done     = (state == LOC_FIN);
    div_last = (state == LOC_DIV) && (cnt == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Numerator with one pixel of bias so that the floor stays nonnegative.
  assign num_sum = (PW+1)'(prod) + (PW+1)'(dst_r);
  assign trial   = {1'b0, rem} - {1'b0, dsh};

  // Operand capture, product and one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (state == LOC_IDLE && start) begin
      coord_r <= coord;
      src_r   <= src;
      dst_r   <= dst;
    end
    if (state == LOC_MUL) begin
      prod <= PW'({coord_r, 1'b1}) * PW'(src_r);
    end
    if (state == LOC_PREP) begin
      rem <= {num_sum, {FRAC_W{1'b0}}};
      dsh <= RW'({dst_r, 1'b0}) << (QW - 1);
      quo <= '0;
      cnt <= CW'(QW - 1);
    end
    if (state == LOC_DIV) begin
      if (!trial[RW]) begin
        rem <= trial[RW-1:0];
      end
      quo <= {quo[QW-2:0], ~trial[RW]};
      dsh <= dsh >> 1;
      cnt <= cnt - 1'b1;
    end
  end

  // Clamp both taps into the source; the fraction is taken before clamping.
  assign hi     = quo[QW-1:FRAC_W];
  assign frac   = quo[FRAC_W-1:0];
  assign idx_hi = (hi >= src_r) ? IW'(src_r - 1'b1) : IW'(hi);
  assign idx_lo = (hi == '0) ? '0 : IW'(hi - 1'b1);

  a_lo_not_above_hi: assert property (@(posedge clk) disable iff (rst)
    done |-> idx_lo <= idx_hi)
    else $error("locator: lower tap above upper tap");

  a_hi_inside_source: assert property (@(posedge clk) disable iff (rst)
    done |-> 32'(idx_hi) < 32'(src_r))
    else $error("locator: upper tap outside the source");

  a_divide_runs: assert property (@(posedge clk) disable iff (rst)
    (state == LOC_DIV && cnt != '0) |=> state == LOC_DIV)
    else $error("locator: divider left early");

endmodule

[sv/bilinear_image_resampler.sv]
// ----------------------------------------------------------------------------
// Bilinear image resampler
// Planar source image store with half-pixel-center bilinear resize reads.
// ----------------------------------------------------------------------------
// A write transfer stores one signed Q8.8 sample and returns a single result
// (zero sample, flag set when the plane or coordinate is out of bounds); it
// is taken one per cycle while the output register is free. A read transfer
// returns the resized sample at a destination pixel, and the next transfer
// is taken only once its result has entered the output register: the
// locators produce one quotient bit per cycle for both axes in parallel,
// then the four taps are read one per cycle through the single port of the
// sample memory and blended in a short multiply-accumulate pipeline. A
// stalled output register holds off the next acceptance. Out-of-bounds reads
// return at once with the flag set. The sample memory needs no clearing
// after reset; a read that touches a never-written sample returns an
// unspecified value.
module bilinear_image_resampler
  import bir_pkg::*;
#(
  parameter int MAX_SIDE = 128,
  parameter int PLANES   = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DAT_W-1:0]       cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       action,
  input  logic [PLANE_W-1:0]         plane,
  input  logic [COORD_W-1:0]         col,
  input  logic [COORD_W-1:0]         line,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic                       bad_coord
);

  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int IW    = $clog2(MAX_SIDE);
  localparam int SIDE2 = MAX_SIDE * MAX_SIDE;
  localparam int DEPTH = PLANES * SIDE2;
  localparam int AW    = $clog2(DEPTH);

  top_state_t state, state_next;

  // Configuration registers.
  logic [SRC_CFG_W-1:0] source_width;
  logic [SRC_CFG_W-1:0] source_height;
  logic [TGT_CFG_W-1:0] target_width;
  logic [TGT_CFG_W-1:0] target_height;

  logic [SW-1:0]        sw_eff;
  logic [SW-1:0]        sh_eff;
  logic [TGT_CFG_W-1:0] tw_eff;
  logic [TGT_CFG_W-1:0] th_eff;

  // Handshake and sequencing controls.
  logic in_acc;
  logic in_bad;
  logic out_free;
  logic loc_start;
  logic mem_we;
  logic direct;
  logic load_direct;
  logic load_held;
  logic fetch;
  logic drain_end;

  // Locator results.
  logic              loc_x_done;
  logic              loc_y_done;
  logic [IW-1:0]     x0, x1, y0, y1;
  logic [FRAC_W-1:0] fx, fy;

  // Sample memory and blend pipeline.
  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] mem_rdata;
  logic [AW-1:0]              mem_addr;
  logic [PLANE_W-1:0]         rd_plane;
  logic [1:0]                 tap;
  logic                       rd_vld;
  logic                       prod_vld;
  logic [FRAC_W:0]            wx, wy;
  logic [WGT_W-1:0]           wgt;
  logic signed [ACC_W-1:0]    prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    rsum;
  logic signed [SAMPLE_W-1:0] res_sample;
  logic                       res_bad;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SRC_CFG_W'(128);
      source_height <= SRC_CFG_W'(128);
      target_width  <= TGT_CFG_W'(128);
      target_height <= TGT_CFG_W'(128);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SOURCE_WIDTH:  source_width  <= cfg_data[SRC_CFG_W-1:0];
        CFG_SOURCE_HEIGHT: source_height <= cfg_data[SRC_CFG_W-1:0];
        CFG_TARGET_WIDTH:  target_width  <= cfg_data[TGT_CFG_W-1:0];
        CFG_TARGET_HEIGHT: target_height <= cfg_data[TGT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes: zero counts as one, a source above the store as full.
  always_comb begin
    if (source_width == '0) sw_eff = SW'(1);
    else if (32'(source_width) > MAX_SIDE) sw_eff = SW'(MAX_SIDE);
    else sw_eff = SW'(source_width);
    if (source_height == '0) sh_eff = SW'(1);
    else if (32'(source_height) > MAX_SIDE) sh_eff = SW'(MAX_SIDE);
    else sh_eff = SW'(source_height);
    tw_eff = (target_width == '0) ? TGT_CFG_W'(1) : target_width;
    th_eff = (target_height == '0) ? TGT_CFG_W'(1) : target_height;
  end

  // Bounds check of the incoming item.
  always_comb begin
    if (action == ACTION_WRITE) begin
      in_bad = (32'(plane) >= PLANES) || (32'(col) >= 32'(sw_eff))
            || (32'(line) >= 32'(sh_eff));
    end else begin
      in_bad = (32'(plane) >= PLANES) || (32'(col) >= 32'(tw_eff))
            || (32'(line) >= 32'(th_eff));
    end
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall    = (state != ST_IDLE);
    in_acc      = in_valid && (state == ST_IDLE);
    out_free    = !out_valid || !out_stall;
    loc_start   = in_acc && (action == ACTION_READ) && !in_bad;
    mem_we      = in_acc && (action == ACTION_WRITE) && !in_bad;
    direct      = in_acc && !loc_start;
    load_direct = direct && out_free;
    load_held   = (state == ST_FINISH) && out_free;
    fetch       = (state == ST_FETCH);
    drain_end   = (state == ST_DRAIN) && !rd_vld && !prod_vld;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (loc_start) state_next = ST_LOCATE;
        else if (direct && !out_free) state_next = ST_FINISH;
      end
      ST_LOCATE: if (loc_x_done) state_next = ST_FETCH;
      ST_FETCH:  if (tap == 2'd3) state_next = ST_DRAIN;
      ST_DRAIN:  if (drain_end) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // One locator per axis; both start together and finish together.
  bir_locate #(.MAX_SIDE(MAX_SIDE)) u_loc_x (
    .clk    (clk),
    .rst    (rst),
    .start  (loc_start),
    .coord  (col),
    .src    (sw_eff),
    .dst    (tw_eff),
    .done   (loc_x_done),
    .idx_lo (x0),
    .idx_hi (x1),
    .frac   (fx)
  );

  bir_locate #(.MAX_SIDE(MAX_SIDE)) u_loc_y (
    .clk    (clk),
    .rst    (rst),
    .start  (loc_start),
    .coord  (line),
    .src    (sh_eff),
    .dst    (th_eff),
    .done   (loc_y_done),
    .idx_lo (y0),
    .idx_hi (y1),
    .frac   (fy)
  );

  // Single memory port: the tap address while fetching, else the incoming write address.
  always_comb begin
    if (fetch) begin
      mem_addr = AW'(32'(rd_plane) * SIDE2
                   + 32'(tap[1] ? y1 : y0) * MAX_SIDE
                   + 32'(tap[0] ? x1 : x0));
    end else begin
      mem_addr = AW'(32'(plane) * SIDE2
                   + 32'(line[IW-1:0]) * MAX_SIDE
                   + 32'(col[IW-1:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= sample_in;
    end
    mem_rdata <= mem[mem_addr];
  end

  // Tap weights: bit 0 of the tap picks the right column, bit 1 the lower row.
  assign wx = tap[0] ? {1'b0, fx} : (FRAC_W+1)'(256) - {1'b0, fx};
  assign wy = tap[1] ? {1'b0, fy} : (FRAC_W+1)'(256) - {1'b0, fy};

  // Fetch counter and pipeline valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap      <= '0;
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      if (loc_start) tap <= '0;
      else if (fetch) tap <= tap + 1'b1;
      rd_vld   <= fetch;
      prod_vld <= rd_vld;
    end
  end

  // Weight, product and accumulation, one register after each multiply.
  always_ff @(posedge clk) begin
    if (loc_start) begin
      rd_plane <= plane;
    end
    if (fetch) begin
      wgt <= WGT_W'(wx * wy);
    end
    if (rd_vld) begin
      prod <= ACC_W'(mem_rdata) * $signed({1'b0, wgt});
    end
    if (loc_start) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + prod;
    end
  end

  // Round half up to Q8.8; the blend never leaves the range of its taps.
  assign rsum = acc + ACC_W'(32768);

  // Result held while the output register is still occupied.
  always_ff @(posedge clk) begin
    if (direct) begin
      res_sample <= '0;
      res_bad    <= in_bad;
    end else if (drain_end) begin
      res_sample <= rsum[31:16];
      res_bad    <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_direct || load_held) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      sample_out <= '0;
      bad_coord  <= in_bad;
    end else if (load_held) begin
      sample_out <= res_sample;
      bad_coord  <= res_bad;
    end
  end

  a_locators_in_step: assert property (@(posedge clk) disable iff (rst)
    loc_x_done |-> loc_y_done)
    else $error("resampler: axis locators out of step");

  a_locate_only_when_waiting: assert property (@(posedge clk) disable iff (rst)
    loc_x_done |-> state == ST_LOCATE)
    else $error("resampler: locator finished outside the locate phase");

  a_read_feeds_product: assert property (@(posedge clk) disable iff (rst)
    rd_vld |=> prod_vld)
    else $error("resampler: tap read lost in the blend pipeline");

  a_flag_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_coord) |-> sample_out == '0)
    else $error("resampler: flagged result carries a sample");

  a_no_write_during_blend: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !rd_vld && !prod_vld)
    else $error("resampler: store written while a blend is in flight");

endmodule
